### rtl/core/rbst_pkg.sv
// Shared types and constants for the ray/box slab test.
package rbst_pkg;

  localparam int unsigned NumAxes = 3;

  // Per-axis status that travels beside the divider pipeline.
  typedef struct packed {
    logic zero;     // direction component is zero
    logic in_slab;  // origin lies between both planes, inclusive
  } axis_st_t;

endpackage

### rtl/core/rbst_div.sv
// Pipelined signed restoring divider, one quotient bit per stage, saturating.
module rbst_div #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                     clk_i,
  input  logic signed [CW:0]       num_i,
  input  logic signed [CW-1:0]     den_i,
  output logic signed [CW+FB-1:0]  quo_o
);

  localparam int unsigned TW = CW + FB;

  logic [TW-1:0] sh_q  [0:TW];
  logic [CW-1:0] rem_q [0:TW];
  logic [CW-1:0] md_q  [0:TW];
  logic          neg_q [0:TW];

  logic [CW:0]   num_neg;
  logic [CW:0]   den_ext;
  logic [CW:0]   den_neg;
  logic [CW-1:0] num_mag;
  logic [CW-1:0] den_mag;

  assign num_neg = -num_i;
  assign den_ext = {den_i[CW-1], den_i};
  assign den_neg = -den_ext;
  assign num_mag = num_i[CW] ? num_neg[CW-1:0] : num_i[CW-1:0];
  assign den_mag = den_i[CW-1] ? den_neg[CW-1:0] : den_i;

  always_ff @(posedge clk_i) begin
    sh_q[0]  <= {num_mag, {FB{1'b0}}};
    rem_q[0] <= '0;
    md_q[0]  <= den_mag;
    neg_q[0] <= num_i[CW] ^ den_i[CW-1];
  end

  for (genvar k = 0; k < TW; k++) begin : g_stage
    logic [CW:0] r2;
    logic [CW:0] diff;
    logic        ge;
    assign r2   = {rem_q[k], sh_q[k][TW-1]};
    assign diff = r2 - {1'b0, md_q[k]};
    assign ge   = (r2 >= {1'b0, md_q[k]});
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? diff[CW-1:0] : r2[CW-1:0];
      sh_q[k+1]  <= {sh_q[k][TW-2:0], ge};
      md_q[k+1]  <= md_q[k];
      neg_q[k+1] <= neg_q[k];
    end
  end

  // Saturate the magnitude, then apply the sign.
  logic [TW-1:0] q;
  logic [TW-1:0] q_neg;
  logic          over_neg;
  assign q        = sh_q[TW];
  assign over_neg = q[TW-1] & (|q[TW-2:0]);
  assign q_neg    = over_neg ? {1'b1, {(TW-1){1'b0}}} : -q;

  always_ff @(posedge clk_i) begin
    if (neg_q[TW]) begin
      quo_o <= q_neg;
    end else if (q[TW-1]) begin
      quo_o <= {1'b0, {(TW-1){1'b1}}};
    end else begin
      quo_o <= q;
    end
  end

endmodule

### rtl/core/rbst_lane.sv
// One axis lane: plane distances, two dividers, and the zero-direction and in-slab checks.
module rbst_lane #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                    clk_i,
  input  logic signed [CW-1:0]    org_i,
  input  logic signed [CW-1:0]    dir_i,
  input  logic signed [CW-1:0]    pa_i,
  input  logic signed [CW-1:0]    pb_i,
  output logic signed [CW+FB-1:0] near_o,
  output logic signed [CW+FB-1:0] far_o,
  output rbst_pkg::axis_st_t      st_o
);

  localparam int unsigned TW = CW + FB;

  logic signed [CW:0]   da_q;
  logic signed [CW:0]   db_q;
  logic signed [CW-1:0] dir_q;
  rbst_pkg::axis_st_t   st_q [0:TW+2];

  always_ff @(posedge clk_i) begin
    da_q  <= {pa_i[CW-1], pa_i} - {org_i[CW-1], org_i};
    db_q  <= {pb_i[CW-1], pb_i} - {org_i[CW-1], org_i};
    dir_q <= dir_i;
    st_q[0].zero    <= (dir_i == '0);
    st_q[0].in_slab <= ((pa_i <= org_i) && (org_i <= pb_i)) ||
                       ((pb_i <= org_i) && (org_i <= pa_i));
  end

  // Hold the status beside the divider until the quotients land.
  for (genvar j = 0; j < TW + 2; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      st_q[j+1] <= st_q[j];
    end
  end

  logic signed [TW-1:0] ta;
  logic signed [TW-1:0] tb;

  rbst_div #(.CW(CW), .FB(FB)) u_div_a (
    .clk_i (clk_i),
    .num_i (da_q),
    .den_i (dir_q),
    .quo_o (ta)
  );

  rbst_div #(.CW(CW), .FB(FB)) u_div_b (
    .clk_i (clk_i),
    .num_i (db_q),
    .den_i (dir_q),
    .quo_o (tb)
  );

  assign near_o = (ta < tb) ? ta : tb;
  assign far_o  = (ta < tb) ? tb : ta;
  assign st_o   = st_q[TW+2];

endmodule

### rtl/core/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test, three axis lanes and a merge stage.
// Throughput: one test per cycle; busy stays low, since the divider pipelines in
// each lane take one quotient bit per stage.
// Reset clears only the valid pipeline; done_o is low until a start drains out.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
module ray_box_slab_test #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                          hit_o
);

  localparam int unsigned TW  = COORD_WIDTH + FRAC_BITS;
  localparam int unsigned LAT = TW + 4;
  localparam int unsigned NA  = rbst_pkg::NumAxes;

  logic signed [COORD_WIDTH-1:0] org [NA];
  logic signed [COORD_WIDTH-1:0] dir [NA];
  logic signed [COORD_WIDTH-1:0] pa  [NA];
  logic signed [COORD_WIDTH-1:0] pb  [NA];
  logic signed [TW-1:0]          nr  [NA];
  logic signed [TW-1:0]          fr  [NA];
  rbst_pkg::axis_st_t            st  [NA];

  assign org[0] = origin_x_i;  assign org[1] = origin_y_i;  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;     assign dir[1] = dir_y_i;     assign dir[2] = dir_z_i;
  assign pa[0]  = box_min_x_i; assign pa[1]  = box_min_y_i; assign pa[2]  = box_min_z_i;
  assign pb[0]  = box_max_x_i; assign pb[1]  = box_max_y_i; assign pb[2]  = box_max_z_i;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbst_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .org_i  (org[a]),
      .dir_i  (dir[a]),
      .pa_i   (pa[a]),
      .pb_i   (pb[a]),
      .near_o (nr[a]),
      .far_o  (fr[a]),
      .st_o   (st[a])
    );
  end

  // Merge: over axes with a nonzero direction, entry is the largest near value, exit the smallest far value.
  logic signed [TW-1:0] entry;
  logic signed [TW-1:0] exitv;
  logic                 ok;
  logic                 hit_d;

  always_comb begin
    entry = {1'b1, {(TW-1){1'b0}}};
    exitv = {1'b0, {(TW-1){1'b1}}};
    ok    = 1'b1;
    for (int a = 0; a < NA; a++) begin
      if (st[a].zero) begin
        ok = ok & st[a].in_slab;
      end else begin
        if (nr[a] > entry) entry = nr[a];
        if (fr[a] < exitv) exitv = fr[a];
      end
    end
    hit_d = ok && !exitv[TW-1] && (entry <= exitv);
  end

  logic [LAT-1:0] vld_q;
  logic           hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[LAT-1];
  assign hit_o  = done_o & hit_q;

endmodule

### rtl/core/rbst_chk.sv
// Port-level checker for the ray/box slab test, bound to the top level.
module rbst_chk #(
  parameter int unsigned LAT = 52
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic hit_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("done without matching start");

  a_hit_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !hit_o)
    else $error("hit outside a result transfer");

endmodule

bind ray_box_slab_test rbst_chk #(.LAT(COORD_WIDTH + FRAC_BITS + 4)) u_rbst_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .hit_o  (hit_o)
);
